// File: design/fcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_pkg
// Types, codes and helpers shared by the floppy controller register file.
// ----------------------------------------------------------------------------
package fcr_pkg;

    typedef enum logic [2:0] {
        KIND_STATUS_RD = 3'd0,
        KIND_TRACK_RD  = 3'd1,
        KIND_SECTOR_RD = 3'd2,
        KIND_DATA_RD   = 3'd3,
        KIND_CMD_WR    = 3'd4,
        KIND_TRACK_WR  = 3'd5,
        KIND_SECTOR_WR = 3'd6,
        KIND_DATA_WR   = 3'd7
    } t_kind;

    localparam logic [2:0] CFG_TRACK_COUNT  = 3'd0;
    localparam logic [2:0] CFG_HEAD_COUNT   = 3'd1;
    localparam logic [2:0] CFG_SECTORS      = 3'd2;
    localparam logic [2:0] CFG_SECTOR_LEN   = 3'd3;
    localparam logic [2:0] CFG_DIR_FIRST    = 3'd4;
    localparam logic [2:0] CFG_DIR_COUNT    = 3'd5;
    localparam logic [2:0] CFG_HEAD_SELECT  = 3'd6;

    localparam logic [3:0] CMD_RESTORE   = 4'h0;
    localparam logic [3:0] CMD_SEEK      = 4'h1;
    localparam logic [3:0] CMD_READ_ADDR = 4'hC;
    localparam logic [3:0] CMD_FORCE_IRQ = 4'hD;
    localparam logic [2:0] CMD_STEP_IN   = 3'b010;
    localparam logic [2:0] CMD_STEP_OUT  = 3'b011;
    localparam logic [7:0] CMD_DENSITY   = 8'hFF;

    localparam logic [7:0] ST_BUSY   = 8'h01;
    localparam logic [7:0] ST_DRQ    = 8'h02;
    localparam logic [7:0] ST_TRACK0 = 8'h04;
    localparam logic [7:0] ST_SEEKER = 8'h10;
    localparam logic [7:0] ST_HDLOAD = 8'h20;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int          ID_LEN   = 6;

    typedef struct packed {
        logic load;
        logic exec;
        logic crc_step;
        logic crc_last;
        logic mul1;
        logic mul2;
        logic mark;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic crc_req;
        logic mark_req;
        logic out_full;
    } t_dp_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] v);
        logic [15:0] c;
        c = crc_in ^ {v, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/fcr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_ctrl
// Sequencer: accept, execute, CRC bytes, sector-mark multiply, deliver.
// ----------------------------------------------------------------------------
module fcr_ctrl import fcr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_CRC  = 7'b0000100,
        S_MUL1 = 7'b0001000,
        S_MUL2 = 7'b0010000,
        S_MARK = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_cnt      = '0;
                if (i_stat.crc_req) begin
                    n_state = S_CRC;
                end else if (i_stat.mark_req) begin
                    n_state = S_MUL1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CRC: begin
                o_cmd.crc_step = 1'b1;
                n_cnt          = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    o_cmd.crc_last = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("exec did not follow load");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({o_cmd.exec, o_cmd.crc_step, o_cmd.mul1, o_cmd.mul2, o_cmd.mark})
        || !(o_cmd.exec || o_cmd.crc_step || o_cmd.mul1 || o_cmd.mul2 || o_cmd.mark))
        else $error("overlapping datapath commands");
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul1 |=> o_cmd.mul2 ##1 o_cmd.mark)
        else $error("mark sequence broken");
`endif

endmodule
`default_nettype wire

// File: design/fcr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_dp
// Register file, command execution, ID bytes with CRC and output register.
// ----------------------------------------------------------------------------
module fcr_dp import fcr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_wdata,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_rdata,
    output logic             o_irq
);

    logic [7:0]  r_track_count, r_sectors;
    logic [1:0]  r_head_count;
    logic [10:0] r_sector_len;
    logic [15:0] r_dir_first, r_dir_count;
    logic        r_head_select;

    logic [7:0]  r_status, n_status;
    logic [7:0]  r_head_track, n_head_track;
    logic [7:0]  r_track_reg, n_track_reg;
    logic [7:0]  r_sector_reg, n_sector_reg;
    logic [7:0]  r_data_latch, n_data_latch;
    logic        r_step_out, n_step_out;
    logic [9:0]  r_busy_left, n_busy_left;
    logic        r_index_tog, n_index_tog;
    logic        r_drq_hold, n_drq_hold;
    logic [2:0]  r_id_index, n_id_index;
    logic [2:0]  r_id_left, n_id_left;
    logic [7:0]  r_next_sec, n_next_sec;
    logic        r_irq_line, n_irq_line;
    logic [7:0]  r_id_bytes [ID_LEN];
    logic        n_id_load;

    logic [2:0]  r_kind;
    logic [7:0]  r_wdata;
    logic [7:0]  r_res_rdata, n_res_rdata;
    logic [15:0] r_crc;
    logic [31:0] r_crc_sh;
    logic [9:0]  r_prod1;
    logic [17:0] r_rel;
    logic        r_out_valid;
    logic [7:0]  r_out_rdata;
    logic        r_out_irq;

    logic [2:0]  w_rate;
    logic [7:0]  w_mul;
    logic [10:0] w_busy_full;
    logic        w_range_bad;
    logic [15:0] w_crc_next;
    logic [16:0] w_dir_end;
    logic [7:0]  w_sec_inc;

    assign w_range_bad = (r_head_track >= r_track_count)
                      || ({1'b0, r_head_select} >= r_head_count)
                      || (r_sector_reg >= r_sectors);
    assign w_crc_next  = crc_byte(r_crc, r_crc_sh[7:0]);
    assign w_dir_end   = {1'b0, r_dir_first} + {1'b0, r_dir_count};
    assign w_sec_inc   = r_next_sec + 8'd1;
    assign w_rate      = {1'b0, r_wdata[1:0]} + 3'd1;

    always_comb begin
        if (r_wdata[7:4] == CMD_RESTORE) begin
            w_mul = r_head_track;
        end else if (r_wdata[7:4] == CMD_SEEK) begin
            w_mul = (r_data_latch >= r_head_track) ? r_data_latch - r_head_track
                                                  : r_head_track - r_data_latch;
        end else begin
            w_mul = 8'd1;
        end
        w_busy_full = {3'd0, w_mul} * {8'd0, w_rate};
    end

    always_comb begin
        n_status     = r_status;
        n_head_track = r_head_track;
        n_track_reg  = r_track_reg;
        n_sector_reg = r_sector_reg;
        n_data_latch = r_data_latch;
        n_step_out   = r_step_out;
        n_busy_left  = r_busy_left;
        n_index_tog  = r_index_tog;
        n_drq_hold   = r_drq_hold;
        n_id_index   = r_id_index;
        n_id_left    = r_id_left;
        n_next_sec   = r_next_sec;
        n_irq_line   = r_irq_line;
        n_res_rdata  = 8'h00;
        n_id_load    = 1'b0;
        case (t_kind'(r_kind))
            KIND_STATUS_RD: begin
                n_res_rdata = r_status;
                n_irq_line  = 1'b0;
                if (r_busy_left != '0) begin
                    n_busy_left = r_busy_left - 10'd1;
                    if (r_busy_left == 10'd1) begin
                        n_status = n_status & ~ST_BUSY;
                    end
                end
                if (r_index_tog) begin
                    n_status = n_status ^ ST_DRQ;
                end
                if (r_drq_hold) begin
                    n_status = n_status | ST_DRQ;
                end
            end
            KIND_TRACK_RD:  n_res_rdata = r_track_reg;
            KIND_SECTOR_RD: n_res_rdata = r_sector_reg;
            KIND_DATA_RD: begin
                if (r_id_left != '0) begin
                    n_status  = n_status & ~ST_DRQ;
                    n_id_left = r_id_left - 3'd1;
                    if (r_id_left == 3'd1) begin
                        n_status   = n_status & ~ST_BUSY;
                        n_drq_hold = 1'b0;
                        n_irq_line = 1'b1;
                    end
                    n_data_latch = (r_id_index < 3'(ID_LEN)) ? r_id_bytes[r_id_index] : 8'h00;
                    n_id_index   = r_id_index + 3'd1;
                end
                n_res_rdata = n_data_latch;
            end
            KIND_CMD_WR: begin
                if ((r_wdata | 8'h01) == CMD_DENSITY) begin
                    n_status = r_status;
                end else if (r_wdata[7:4] == CMD_FORCE_IRQ) begin
                    n_id_left   = '0;
                    n_id_index  = '0;
                    n_status    = r_status & ~(ST_DRQ | ST_BUSY);
                    n_drq_hold  = 1'b0;
                    n_index_tog = 1'b1;
                    n_irq_line  = 1'b0;
                    n_busy_left = '0;
                end else if (r_wdata[7]) begin
                    n_index_tog = 1'b0;
                    if (r_wdata[7:4] == CMD_READ_ADDR) begin
                        if (w_range_bad) begin
                            n_status = ST_SEEKER;
                        end else begin
                            n_id_load   = 1'b1;
                            n_next_sec  = (w_sec_inc == r_sectors) ? 8'h00 : w_sec_inc;
                            n_id_index  = '0;
                            n_id_left   = 3'(ID_LEN);
                            n_drq_hold  = 1'b1;
                            n_status    = ST_DRQ | ST_BUSY;
                            n_busy_left = '0;
                        end
                    end
                end else begin
                    if (r_wdata[7:4] == CMD_RESTORE) begin
                        n_head_track = 8'h00;
                        n_track_reg  = 8'h00;
                    end else if (r_wdata[7:4] == CMD_SEEK) begin
                        n_head_track = r_data_latch;
                    end else begin
                        if (r_wdata[7:5] == CMD_STEP_IN) begin
                            n_step_out = 1'b0;
                        end else if (r_wdata[7:5] == CMD_STEP_OUT) begin
                            n_step_out = 1'b1;
                        end
                        n_head_track = n_step_out ? r_head_track - 8'd1 : r_head_track + 8'd1;
                    end
                    n_busy_left = w_busy_full[9:0];
                    if (n_busy_left != '0) begin
                        n_status = ST_BUSY;
                    end
                    n_index_tog = 1'b1;
                    if (n_head_track >= r_track_count) begin
                        n_status = n_status | ST_SEEKER;
                    end
                    if (n_head_track == 8'h00) begin
                        n_status = n_status | ST_TRACK0;
                    end
                    if (r_wdata[4]) begin
                        n_track_reg = n_head_track;
                    end
                    if (r_wdata[3]) begin
                        n_status = n_status | ST_HDLOAD;
                    end
                    if (r_wdata[2] && (n_track_reg != n_head_track)) begin
                        n_status = n_status | ST_SEEKER;
                    end
                end
            end
            KIND_TRACK_WR: begin
                n_head_track = r_wdata;
                n_track_reg  = r_wdata;
            end
            KIND_SECTOR_WR: n_sector_reg = r_wdata;
            KIND_DATA_WR:   n_data_latch = r_wdata;
            default: n_res_rdata = 8'h00;
        endcase
    end

    assign o_stat.crc_req  = (r_kind == KIND_CMD_WR) && (r_wdata[7:4] == CMD_READ_ADDR)
                          && !w_range_bad;
    assign o_stat.mark_req = (r_kind == KIND_DATA_RD) && (r_id_left == 3'd1);
    assign o_stat.out_full = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= 8'd40;
            r_head_count  <= 2'd1;
            r_sectors     <= 8'd18;
            r_sector_len  <= 11'd256;
            r_dir_first   <= '0;
            r_dir_count   <= '0;
            r_head_select <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRACK_COUNT: r_track_count <= i_cfg_data[7:0];
                CFG_HEAD_COUNT:  r_head_count  <= i_cfg_data[1:0];
                CFG_SECTORS:     r_sectors     <= i_cfg_data[7:0];
                CFG_SECTOR_LEN:  r_sector_len  <= i_cfg_data[10:0];
                CFG_DIR_FIRST:   r_dir_first   <= i_cfg_data;
                CFG_DIR_COUNT:   r_dir_count   <= i_cfg_data;
                CFG_HEAD_SELECT: r_head_select <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= ST_TRACK0;
            r_head_track <= '0;
            r_track_reg  <= '0;
            r_sector_reg <= '0;
            r_data_latch <= '0;
            r_step_out   <= 1'b0;
            r_busy_left  <= '0;
            r_index_tog  <= 1'b0;
            r_drq_hold   <= 1'b0;
            r_id_index   <= '0;
            r_id_left    <= '0;
            r_next_sec   <= '0;
            r_irq_line   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_status     <= n_status;
                r_head_track <= n_head_track;
                r_track_reg  <= n_track_reg;
                r_sector_reg <= n_sector_reg;
                r_data_latch <= n_data_latch;
                r_step_out   <= n_step_out;
                r_busy_left  <= n_busy_left;
                r_index_tog  <= n_index_tog;
                r_drq_hold   <= n_drq_hold;
                r_id_index   <= n_id_index;
                r_id_left    <= n_id_left;
                r_next_sec   <= n_next_sec;
                r_irq_line   <= n_irq_line;
            end
            if (i_cmd.mark && ({14'd0, r_rel} >= 32'(r_dir_first))
                    && ({14'd0, r_rel} < 32'(w_dir_end))) begin
                r_status <= r_status | ST_HDLOAD;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_wdata <= i_wdata;
        end
        if (i_cmd.exec) begin
            r_res_rdata <= n_res_rdata;
            r_crc       <= CRC_INIT;
            r_crc_sh    <= {5'd0, r_sector_len[10:8], r_next_sec,
                            7'd0, r_head_select, r_head_track};
        end
        if (i_cmd.exec && n_id_load) begin
            r_id_bytes[0] <= r_head_track;
            r_id_bytes[1] <= {7'd0, r_head_select};
            r_id_bytes[2] <= r_next_sec;
            r_id_bytes[3] <= {5'd0, r_sector_len[10:8]};
        end
        if (i_cmd.crc_step) begin
            r_crc    <= w_crc_next;
            r_crc_sh <= {8'd0, r_crc_sh[31:8]};
        end
        if (i_cmd.crc_last) begin
            r_id_bytes[4] <= w_crc_next[7:0];
            r_id_bytes[5] <= w_crc_next[15:8];
        end
        if (i_cmd.mul1) begin
            r_prod1 <= ({2'd0, r_head_track} * {8'd0, r_head_count})
                     + {9'd0, r_head_select};
        end
        if (i_cmd.mul2) begin
            r_rel <= ({8'd0, r_prod1} * {10'd0, r_sectors}) + {10'd0, r_sector_reg};
        end
        if (i_cmd.push) begin
            r_out_rdata <= r_res_rdata;
            r_out_irq   <= r_irq_line;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_out_rdata;
    assign o_irq       = r_out_irq;

`ifndef ASSERT_OFF
    a_drq_hold_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drq_hold == (r_id_left != 3'd0))
        else $error("drq hold out of step with ID count");
    a_id_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_id_left != 3'd0) |-> ((r_id_left + r_id_index) == 3'(ID_LEN)))
        else $error("ID index and count disagree");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || i_out_ready))
        else $error("result pushed over a pending result");
`endif

endmodule
`default_nettype wire

// File: design/floppy_controller_registers.sv
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_controller_registers
// Floppy controller register file for one drive, one bus access per item.
//
//  channel  direction  signals                                   payload
//  s        in         i_s_tvalid o_s_tready i_s_tdata i_s_tuser wdata, kind
//  m        out        o_m_tvalid i_m_tready o_m_tdata           rdata, irq
//  cfg      in         i_cfg_valid o_cfg_ready i_cfg_index/data  register write
//
//  Most items pass accept, execute and deliver. Read address adds the ID CRC,
//  which runs one byte per cycle. The last ID data read adds the sector mark:
//  the relative sector goes through two registered multiplies.
//  Reset is synchronous; no clearing pass. A stalled output holds the result;
//  the next item is accepted meanwhile and waits at delivery.
// ----------------------------------------------------------------------------
module floppy_controller_registers import fcr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] wdata
    input  wire logic [2:0]  i_s_tuser,   // [2:0] kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] rdata, [8] irq, [15:9] zero
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic [7:0] w_rdata;
    logic       w_irq;

    fcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fcr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_kind      (i_s_tuser),
        .i_wdata     (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_rdata     (w_rdata),
        .o_irq       (w_irq)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {7'd0, w_irq, w_rdata};

endmodule
`default_nettype wire
